[hw/rtl/cau_pkg.sv]
// shared types, opcodes, status codes and helper functions for the complex
// arithmetic unit; no dependencies
package cau_pkg;

  // fixed-point format of operands and results
  localparam int FRAC_BITS = 16;

  // opcodes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_MAG = 3'd5;
  localparam logic [2:0] OP_ANG = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // chain cell: quotient bit per part, root bit, rotation in the first cells
  localparam int NCELL        = 32;
  localparam int CIDX_W       = $clog2(NCELL);
  localparam int CORDIC_STEPS = 25;
  localparam int LATENCY      = NCELL + 5;

  // angle datapath
  localparam int ANG_FRAC      = 24;
  localparam int ANG_SH        = ANG_FRAC - FRAC_BITS;
  localparam int DEG_HALF_TURN = 180;
  localparam int XW            = 60;
  localparam int ZW            = 34;
  localparam longint ANG_QUARTER = longint'(DEG_HALF_TURN / 2) << ANG_FRAC;
  localparam longint ANG_RND     = (longint'(1) << ANG_SH) >> 1;
  localparam longint MUL_HALF    = longint'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               equal_flag;
    logic [1:0]         status;
  } out_item_t;

  // word carried along the cell chain
  typedef struct packed {
    logic [2:0]            op;
    logic                  eq;
    logic signed [31:0]    sum_re;
    logic signed [31:0]    sum_im;
    logic                  sum_sat;
    logic                  neg_re;
    logic                  neg_im;
    logic [63:0]           mag_re;
    logic [63:0]           mag_im;
    logic [63:0]           den;
    logic                  den_zero;
    logic                  ovf_re;
    logic                  ovf_im;
    logic [63:0]           rem_re;
    logic [63:0]           rem_im;
    logic [31:0]           bits_re;
    logic [31:0]           bits_im;
    logic [31:0]           q_re;
    logic [31:0]           q_im;
    logic [63:0]           sq_s;
    logic [33:0]           sq_rem;
    logic [31:0]           sq_res;
    logic                  ang_zero;
    logic signed [XW-1:0]  cx;
    logic signed [XW-1:0]  cy;
    logic signed [ZW-1:0]  cz;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } fm_t;

  // signed value from sign and magnitude, clamped to 32 bits
  function automatic fm_t from_mag(input logic neg, input logic [64:0] mag);
    fm_t r;
    r.sat = 1'b0;
    r.val = '0;
    if (neg) begin
      if (mag > 65'h080000000) begin
        r.sat = 1'b1;
        r.val = 32'sh80000000;
      end else begin
        r.val = 32'(~mag + 65'd1);
      end
    end else begin
      if (mag > 65'h07FFFFFFF) begin
        r.sat = 1'b1;
        r.val = 32'sh7FFFFFFF;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  // arctangent of 2^-i in degrees, Q24
  function automatic logic signed [ZW-1:0] atan_q24(input logic [CIDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = ZW'(754974720);
      5'd1:  v = ZW'(445687602);
      5'd2:  v = ZW'(235489088);
      5'd3:  v = ZW'(119537938);
      5'd4:  v = ZW'(60000934);
      5'd5:  v = ZW'(30029717);
      5'd6:  v = ZW'(15018523);
      5'd7:  v = ZW'(7509720);
      5'd8:  v = ZW'(3754917);
      5'd9:  v = ZW'(1877466);
      5'd10: v = ZW'(938734);
      5'd11: v = ZW'(469367);
      5'd12: v = ZW'(234684);
      5'd13: v = ZW'(117342);
      5'd14: v = ZW'(58671);
      5'd15: v = ZW'(29335);
      5'd16: v = ZW'(14668);
      5'd17: v = ZW'(7334);
      5'd18: v = ZW'(3667);
      5'd19: v = ZW'(1833);
      5'd20: v = ZW'(917);
      5'd21: v = ZW'(458);
      5'd22: v = ZW'(229);
      5'd23: v = ZW'(115);
      5'd24: v = ZW'(57);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/cau_prep.sv]
// front end: input register, products, sums and magnitudes feeding the cell chain
// depends on cau_pkg
module cau_prep import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     out_valid,
  output cell_t    out_d
);

  // stage 0: input word
  logic     v0_r;
  in_item_t in_r;

  // stage 1: products
  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [63:0] p_rr1_r, p_ii1_r, p_ri1_r, p_ir1_r;
  logic signed [63:0] p_aa1_r, p_bb1_r, p_dr1_r, p_di1_r;
  logic signed [31:0] ar1_r, ai1_r, sre1_r, sim1_r;
  logic               eq1_r, ssat1_r, angz1_r;
  logic signed [32:0] add_re, add_im;

  // stage 2: sums and rotated start vector
  logic               v2_r;
  logic [2:0]         op2_r;
  logic signed [65:0] nre2_r, nim2_r, nre_nxt, nim_nxt;
  logic [63:0]        den2_r, sq2_r;
  logic signed [31:0] sre2_r, sim2_r;
  logic               eq2_r, ssat2_r, angz2_r;
  logic signed [XW-1:0] cx2_r, cy2_r, cx_nxt, cy_nxt;
  logic signed [ZW-1:0] cz2_r, cz_nxt;
  logic signed [32:0] xa, ya;

  // stage 3
  logic  v3_r;
  cell_t d3_r, d3_nxt;

  // add or subtract, clamped
  always_comb begin
    if (in_r.req_type == OP_SUB) begin
      add_re = 33'(in_r.a_re) - 33'(in_r.b_re);
      add_im = 33'(in_r.a_im) - 33'(in_r.b_im);
    end else begin
      add_re = 33'(in_r.a_re) + 33'(in_r.b_re);
      add_im = 33'(in_r.a_im) + 33'(in_r.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (in_valid) in_r <= in_item;
    op1_r   <= in_r.req_type;
    p_rr1_r <= in_r.a_re * in_r.b_re;
    p_ii1_r <= in_r.a_im * in_r.b_im;
    p_ri1_r <= in_r.a_re * in_r.b_im;
    p_ir1_r <= in_r.a_im * in_r.b_re;
    p_aa1_r <= in_r.a_re * in_r.a_re;
    p_bb1_r <= in_r.a_im * in_r.a_im;
    p_dr1_r <= in_r.b_re * in_r.b_re;
    p_di1_r <= in_r.b_im * in_r.b_im;
    ar1_r   <= in_r.a_re;
    ai1_r   <= in_r.a_im;
    eq1_r   <= (in_r.req_type == OP_EQ) && (in_r.a_re == in_r.b_re)
               && (in_r.a_im == in_r.b_im);
    sre1_r  <= (add_re[32] != add_re[31]) ?
               (add_re[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : add_re[31:0];
    sim1_r  <= (add_im[32] != add_im[31]) ?
               (add_im[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : add_im[31:0];
    ssat1_r <= (add_re[32] != add_re[31]) || (add_im[32] != add_im[31]);
    angz1_r <= (in_r.a_im == 32'sd0) && !in_r.a_re[31];
  end

  // stage 2: numerators and the left half-plane pre-rotation
  always_comb begin
    if (op1_r == OP_MUL) begin
      nre_nxt = 66'(p_rr1_r) - 66'(p_ii1_r);
      nim_nxt = 66'(p_ri1_r) + 66'(p_ir1_r);
    end else begin
      nre_nxt = 66'(p_rr1_r) + 66'(p_ii1_r);
      nim_nxt = 66'(p_ir1_r) - 66'(p_ri1_r);
    end
    xa = 33'(ar1_r);
    ya = 33'(ai1_r);
    cz_nxt = '0;
    if (ar1_r[31]) begin
      if (!ai1_r[31]) begin
        xa = 33'(ai1_r);
        ya = -33'(ar1_r);
        cz_nxt = ZW'(ANG_QUARTER);
      end else begin
        xa = -33'(ai1_r);
        ya = 33'(ar1_r);
        cz_nxt = -ZW'(ANG_QUARTER);
      end
    end
    cx_nxt = XW'(xa) <<< ANG_FRAC;
    cy_nxt = XW'(ya) <<< ANG_FRAC;
  end

  always_ff @(posedge clk) begin
    op2_r   <= op1_r;
    nre2_r  <= nre_nxt;
    nim2_r  <= nim_nxt;
    den2_r  <= p_dr1_r + p_di1_r;
    sq2_r   <= p_aa1_r + p_bb1_r;
    sre2_r  <= sre1_r;
    sim2_r  <= sim1_r;
    eq2_r   <= eq1_r;
    ssat2_r <= ssat1_r;
    angz2_r <= angz1_r;
    cx2_r   <= cx_nxt;
    cy2_r   <= cy_nxt;
    cz2_r   <= cz_nxt;
  end

  // stage 3: magnitudes, divider start remainder and overflow check
  always_comb begin
    d3_nxt          = '0;
    d3_nxt.op       = op2_r;
    d3_nxt.eq       = eq2_r;
    d3_nxt.sum_re   = sre2_r;
    d3_nxt.sum_im   = sim2_r;
    d3_nxt.sum_sat  = ssat2_r;
    d3_nxt.neg_re   = nre2_r[65];
    d3_nxt.neg_im   = nim2_r[65];
    d3_nxt.mag_re   = nre2_r[65] ? 64'(-nre2_r) : nre2_r[63:0];
    d3_nxt.mag_im   = nim2_r[65] ? 64'(-nim2_r) : nim2_r[63:0];
    d3_nxt.den      = den2_r;
    d3_nxt.den_zero = (den2_r == 64'd0);
    d3_nxt.rem_re   = d3_nxt.mag_re >> (32 - FRAC_BITS);
    d3_nxt.rem_im   = d3_nxt.mag_im >> (32 - FRAC_BITS);
    d3_nxt.ovf_re   = d3_nxt.rem_re >= den2_r;
    d3_nxt.ovf_im   = d3_nxt.rem_im >= den2_r;
    d3_nxt.bits_re  = 32'(d3_nxt.mag_re << FRAC_BITS);
    d3_nxt.bits_im  = 32'(d3_nxt.mag_im << FRAC_BITS);
    d3_nxt.sq_s     = sq2_r;
    d3_nxt.ang_zero = angz2_r;
    d3_nxt.cx       = cx2_r;
    d3_nxt.cy       = cy2_r;
    d3_nxt.cz       = cz2_r;
  end

  always_ff @(posedge clk) begin
    d3_r <= d3_nxt;
  end

  assign out_valid = v3_r;
  assign out_d     = d3_r;

endmodule

[hw/rtl/cau_cell.sv]
// one chain cell: quotient bit per part, root bit, rotation in the first cells
// depends on cau_pkg
module cau_cell import cau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CIDX_W-1:0] idx,
  input  logic              in_valid,
  input  cell_t             in_d,
  output logic              out_valid,
  output cell_t             out_d
);

  logic  valid_r;
  cell_t d_r, d_nxt;
  logic [64:0] t_re, t_im;
  logic [35:0] sq_t;
  logic [33:0] sq_trial;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    d_nxt = in_d;

    // restoring divide step, real part
    t_re = {in_d.rem_re, in_d.bits_re[31]};
    if (t_re >= {1'b0, in_d.den}) begin
      d_nxt.rem_re = 64'(t_re - {1'b0, in_d.den});
      d_nxt.q_re   = {in_d.q_re[30:0], 1'b1};
    end else begin
      d_nxt.rem_re = t_re[63:0];
      d_nxt.q_re   = {in_d.q_re[30:0], 1'b0};
    end
    d_nxt.bits_re = {in_d.bits_re[30:0], 1'b0};

    // restoring divide step, imaginary part
    t_im = {in_d.rem_im, in_d.bits_im[31]};
    if (t_im >= {1'b0, in_d.den}) begin
      d_nxt.rem_im = 64'(t_im - {1'b0, in_d.den});
      d_nxt.q_im   = {in_d.q_im[30:0], 1'b1};
    end else begin
      d_nxt.rem_im = t_im[63:0];
      d_nxt.q_im   = {in_d.q_im[30:0], 1'b0};
    end
    d_nxt.bits_im = {in_d.bits_im[30:0], 1'b0};

    // square root step, two radicand bits
    sq_t     = {in_d.sq_rem, in_d.sq_s[63:62]};
    sq_trial = {in_d.sq_res, 2'b01};
    if (sq_t >= 36'(sq_trial)) begin
      d_nxt.sq_rem = 34'(sq_t - 36'(sq_trial));
      d_nxt.sq_res = {in_d.sq_res[30:0], 1'b1};
    end else begin
      d_nxt.sq_rem = sq_t[33:0];
      d_nxt.sq_res = {in_d.sq_res[30:0], 1'b0};
    end
    d_nxt.sq_s = {in_d.sq_s[61:0], 2'b00};

    // vectoring rotation, only in the first cells
    xs = in_d.cx >>> idx;
    ys = in_d.cy >>> idx;
    if (idx < CIDX_W'(CORDIC_STEPS)) begin
      if (!in_d.cy[XW-1]) begin
        d_nxt.cx = in_d.cx + ys;
        d_nxt.cy = in_d.cy - xs;
        d_nxt.cz = in_d.cz + atan_q24(idx);
      end else begin
        d_nxt.cx = in_d.cx - ys;
        d_nxt.cy = in_d.cy + xs;
        d_nxt.cz = in_d.cz - atan_q24(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

[hw/rtl/cau_post.sv]
// back end: rounding, saturation and result selection into the output register
// depends on cau_pkg
module cau_post import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cell_t     in_d,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic signed [34:0] A_MAX = 35'sd2147483647;
  localparam logic signed [34:0] A_MIN = -35'sd2147483648;

  logic      valid_r;
  out_item_t item_r, item_nxt;
  logic      sat;
  fm_t       fm_re, fm_im;
  logic [64:0] mm_re, mm_im;
  logic      rb_re, rb_im, rb_sq;
  logic signed [34:0] a_sum, a_rnd;

  always_comb begin
    item_nxt = '0;
    sat      = 1'b0;
    fm_re    = '0;
    fm_im    = '0;
    mm_re    = '0;
    mm_im    = '0;
    rb_re    = ({in_d.rem_re, 1'b0} >= {1'b0, in_d.den});
    rb_im    = ({in_d.rem_im, 1'b0} >= {1'b0, in_d.den});
    rb_sq    = (in_d.sq_rem > 34'(in_d.sq_res));
    a_sum    = 35'(in_d.cz) + 35'(ANG_RND);
    a_rnd    = a_sum >>> ANG_SH;

    case (in_d.op)
      OP_ADD, OP_SUB: begin
        item_nxt.res_re = in_d.sum_re;
        item_nxt.res_im = in_d.sum_im;
        sat             = in_d.sum_sat;
      end
      OP_MUL: begin
        // round half away from zero on the magnitude
        mm_re = ({1'b0, in_d.mag_re} + 65'(MUL_HALF)) >> FRAC_BITS;
        mm_im = ({1'b0, in_d.mag_im} + 65'(MUL_HALF)) >> FRAC_BITS;
        fm_re = from_mag(in_d.neg_re, mm_re);
        fm_im = from_mag(in_d.neg_im, mm_im);
        item_nxt.res_re = fm_re.val;
        item_nxt.res_im = fm_im.val;
        sat             = fm_re.sat | fm_im.sat;
      end
      OP_DIV: begin
        if (!in_d.den_zero) begin
          mm_re = {33'd0, in_d.q_re} + 65'(rb_re);
          mm_im = {33'd0, in_d.q_im} + 65'(rb_im);
          fm_re = from_mag(in_d.neg_re, mm_re);
          fm_im = from_mag(in_d.neg_im, mm_im);
          // quotient beyond the chain's reach always clamps
          if (in_d.ovf_re) begin
            fm_re.val = in_d.neg_re ? 32'sh80000000 : 32'sh7FFFFFFF;
            fm_re.sat = 1'b1;
          end
          if (in_d.ovf_im) begin
            fm_im.val = in_d.neg_im ? 32'sh80000000 : 32'sh7FFFFFFF;
            fm_im.sat = 1'b1;
          end
          item_nxt.res_re = fm_re.val;
          item_nxt.res_im = fm_im.val;
          sat             = fm_re.sat | fm_im.sat;
        end
      end
      OP_EQ: begin
        item_nxt.equal_flag = in_d.eq;
      end
      OP_MAG: begin
        fm_re = from_mag(1'b0, 65'(in_d.sq_res) + 65'(rb_sq));
        item_nxt.res_re = fm_re.val;
        sat             = fm_re.sat;
      end
      OP_ANG: begin
        if (!in_d.ang_zero) begin
          if (a_rnd > A_MAX) begin
            item_nxt.res_re = 32'sh7FFFFFFF;
            sat             = 1'b1;
          end else if (a_rnd < A_MIN) begin
            item_nxt.res_re = 32'sh80000000;
            sat             = 1'b1;
          end else begin
            item_nxt.res_re = a_rnd[31:0];
          end
        end
      end
      default: begin
        item_nxt = '0;
      end
    endcase

    // status, divide by zero wins
    if (in_d.op == OP_DIV && in_d.den_zero) item_nxt.status = ST_DIV0;
    else if (sat)                           item_nxt.status = ST_SAT;
    else                                    item_nxt.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
// top level of the complex arithmetic unit: front end, chain of cells, back end
// depends on cau_pkg, cau_prep, cau_cell, cau_post
//
// Takes one word per clock whenever busy is low (busy is high in reset and stays
// high until the busy_r register samples reset released) and returns each
// result as a one-cycle out_valid strobe; results cannot be held off by the
// receiver and come out in order. The results pass through the 32-cell chain
// that produces one quotient bit per part, one square-root bit and, in the first
// 25 cells, one vectoring rotation per cell; four more register stages form the
// operands, products and sums in front of it and one rounds and saturates behind it.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic  busy_r;
  logic  accept;
  logic  ch_v [NCELL+1];
  cell_t ch_d [NCELL+1];

  // busy is set in reset and cleared by the register once reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // operand preparation
  cau_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_item),
    .out_valid (ch_v[0]),
    .out_d     (ch_d[0])
  );

  // chain of cells
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (CIDX_W'(g)),
      .in_valid  (ch_v[g]),
      .in_d      (ch_d[g]),
      .out_valid (ch_v[g+1]),
      .out_d     (ch_d[g+1])
    );
  end

  // rounding and result register
  cau_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ch_v[NCELL]),
    .in_d      (ch_d[NCELL]),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[hw/rtl/cau_checker.sv]
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit
module cau_checker import cau_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // every accepted word gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  // no result without a word accepted the latency before
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  // divide by zero gives zero parts
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_DIV0) |->
      (out_item.res_re == 32'sd0 && out_item.res_im == 32'sd0 && !out_item.equal_flag))
    else $error("divide by zero result not cleared");

  // equal flag comes only with clean zero parts
  a_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.equal_flag) |->
      (out_item.status == ST_OK && out_item.res_re == 32'sd0 && out_item.res_im == 32'sd0))
    else $error("equal flag with other fields set");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
